FILE: rtl/rpld_pkg.sv
`default_nettype none
package rpld_pkg;

	// Largest image dimension; row and column fields span 0 .. MAX_DIM-1
	localparam int unsigned MAX_DIM = 2048;
	localparam int unsigned POS_W   = $clog2(MAX_DIM);
	localparam int unsigned CNT_W   = POS_W + 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIM);

	// Result queue
	localparam int unsigned RES_DEPTH = 4;
	localparam int unsigned PTR_W     = $clog2(RES_DEPTH);

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COL_LO         = 3'd0,
		REG_COL_HI         = 3'd1,
		REG_ROW_LO         = 3'd2,
		REG_ROW_HI         = 3'd3,
		REG_LINE_THRESHOLD = 3'd4,
		REG_MIN_LINE_GAP   = 3'd5,
		REG_MIN_PEAK_SEP   = 3'd6
	} cfg_reg_t;

	// Result kinds
	localparam logic KIND_LINE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic             pixel_black;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             row_end;
		logic             frame_end;
	} pixel_t;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] row_pos;
		logic [CNT_W-1:0] count;
		logic [POS_W-1:0] second_row_pos;
		logic [CNT_W-1:0] second_count;
		logic [CNT_W-1:0] line_total;
		logic             last;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/rpld_result_fifo.sv
`default_nettype none
module rpld_result_fifo import rpld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  result_t    push_data0,
	input  result_t    push_data1,
	output logic       has_room,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    result
);

	result_t          mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             pop;
	logic [PTR_W-1:0] wr_ptr_p1;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign result    = mem_q[rd_ptr_q];
	// Room for the worst case of two pushes, ignoring a pop in the same cycle
	assign has_room  = (count_q <= (PTR_W+1)'(RES_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_data0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/row_projection_line_detector.sv
`default_nettype none
// Row projection line detector. Pixels of a binary image arrive in raster order, one per
// transfer, and the block accepts one pixel every clock while the input is not stalled.
// Each accepted pixel lands in an input register; once the result queue has room for two
// results, the row count, the top-two peak tracker and the line detector update from it
// and any results enter a four-entry result queue, whose oldest entry drives the output.
// A row end inside the row band may add a line event; a frame end adds a summary (after
// the line event of the last row, if any) and clears all tracking state, while the
// configuration registers keep their values. Results leave the queue one per clock while
// the output side is ready; the input stalls only while the queue holds more than two
// entries, which happens when the output side is held off or when pixels that each add
// two results come faster than the queue drains. Write the configuration port only while
// no pixel or result is in flight.
module row_projection_line_detector import rpld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pixel_t               pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_wdata
);

	// Configuration registers
	logic [POS_W-1:0] col_lo_q;
	logic [CNT_W-1:0] col_hi_q;
	logic [POS_W-1:0] row_lo_q;
	logic [CNT_W-1:0] row_hi_q;
	logic [CNT_W-1:0] line_threshold_q;
	logic [POS_W-1:0] min_line_gap_q;
	logic [POS_W-1:0] min_peak_sep_q;

	// Tracking state
	logic [CNT_W-1:0] row_black_count_q;
	logic [CNT_W-1:0] best_count_q;
	logic [POS_W-1:0] best_row_q;
	logic [CNT_W-1:0] second_count_q;
	logic [POS_W-1:0] second_row_q;
	logic [POS_W-1:0] last_line_row_q;
	logic [CNT_W-1:0] lines_found_q;

	// Input register
	pixel_t pixel_s1;
	logic   valid_s1;
	logic   advance_s1;
	logic   has_room;

	// Stage-one logic
	logic             col_hit;
	logic [CNT_W-1:0] row_cnt;
	logic             row_close;
	logic             in_band;
	logic             peak_far;
	logic             line_far;
	logic             take_peak;
	logic             to_best;
	logic             take_line;
	logic [CNT_W-1:0] best_count_nxt;
	logic [POS_W-1:0] best_row_nxt;
	logic [CNT_W-1:0] second_count_nxt;
	logic [POS_W-1:0] second_row_nxt;
	logic [CNT_W-1:0] lines_found_nxt;
	result_t          line_res;
	result_t          sum_res;
	logic [1:0]       push_cnt;
	result_t          push_data0;

	// Hold the input register until the queue can take both possible results
	assign advance_s1 = valid_s1 && has_room;
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_s1 <= pixel;
		end
	end

	// Count black pixels inside the column window, saturating at MAX_DIM
	assign col_hit = pixel_s1.pixel_black && (pixel_s1.col >= col_lo_q)
		&& ({1'b0, pixel_s1.col} < col_hi_q);
	assign row_cnt = row_black_count_q
		+ CNT_W'(col_hit && (row_black_count_q < CNT_MAX));

	// A frame end also closes the row
	assign row_close = pixel_s1.row_end || pixel_s1.frame_end;
	assign in_band   = (pixel_s1.row >= row_lo_q) && ({1'b0, pixel_s1.row} < row_hi_q);

	// Distances as sums: a row before the reference is never far enough
	assign peak_far = {1'b0, pixel_s1.row} > ({1'b0, best_row_q} + {1'b0, min_peak_sep_q});
	assign line_far = {1'b0, pixel_s1.row} >= ({1'b0, last_line_row_q} + {1'b0, min_line_gap_q});

	assign take_peak = row_close && in_band && (second_count_q < row_cnt) && peak_far;
	assign to_best   = best_count_q < row_cnt;
	assign take_line = row_close && in_band && (row_cnt > line_threshold_q) && line_far;

	// Top-two tracker: a new best pushes the old best down to second place
	always_comb begin
		best_count_nxt   = best_count_q;
		best_row_nxt     = best_row_q;
		second_count_nxt = second_count_q;
		second_row_nxt   = second_row_q;
		if (take_peak) begin
			if (to_best) begin
				best_count_nxt   = row_cnt;
				best_row_nxt     = pixel_s1.row;
				second_count_nxt = best_count_q;
				second_row_nxt   = best_row_q;
			end else begin
				second_count_nxt = row_cnt;
				second_row_nxt   = pixel_s1.row;
			end
		end
	end

	assign lines_found_nxt = lines_found_q
		+ CNT_W'(take_line && (lines_found_q < CNT_MAX));

	always_comb begin
		line_res                = '0;
		line_res.kind           = KIND_LINE;
		line_res.row_pos        = pixel_s1.row;
		line_res.count          = row_cnt;
		line_res.line_total     = lines_found_nxt;
		line_res.last           = !pixel_s1.frame_end;

		sum_res                 = '0;
		sum_res.kind            = KIND_SUMMARY;
		sum_res.row_pos         = best_row_nxt;
		sum_res.count           = best_count_nxt;
		sum_res.second_row_pos  = second_row_nxt;
		sum_res.second_count    = second_count_nxt;
		sum_res.line_total      = lines_found_nxt;
		sum_res.last            = 1'b1;
	end

	// Line event goes first when both results come from one pixel
	assign push_cnt   = advance_s1 ? (2'(take_line) + 2'(pixel_s1.frame_end)) : 2'd0;
	assign push_data0 = take_line ? line_res : sum_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_black_count_q <= '0;
			best_count_q      <= '0;
			best_row_q        <= '0;
			second_count_q    <= '0;
			second_row_q      <= '0;
			last_line_row_q   <= '0;
			lines_found_q     <= '0;
		end else if (advance_s1) begin
			if (pixel_s1.frame_end) begin
				// Clear tracking for the next frame
				row_black_count_q <= '0;
				best_count_q      <= '0;
				best_row_q        <= '0;
				second_count_q    <= '0;
				second_row_q      <= '0;
				last_line_row_q   <= '0;
				lines_found_q     <= '0;
			end else begin
				row_black_count_q <= row_close ? '0 : row_cnt;
				best_count_q      <= best_count_nxt;
				best_row_q        <= best_row_nxt;
				second_count_q    <= second_count_nxt;
				second_row_q      <= second_row_nxt;
				lines_found_q     <= lines_found_nxt;
				if (take_line) begin
					last_line_row_q <= pixel_s1.row;
				end
			end
		end
	end

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_lo_q         <= POS_W'(290);
			col_hi_q         <= CNT_W'(870);
			row_lo_q         <= POS_W'(30);
			row_hi_q         <= CNT_W'(787);
			line_threshold_q <= CNT_W'(450);
			min_line_gap_q   <= POS_W'(8);
			min_peak_sep_q   <= POS_W'(5);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COL_LO:         col_lo_q         <= cfg_wdata[POS_W-1:0];
				REG_COL_HI:         col_hi_q         <= cfg_wdata;
				REG_ROW_LO:         row_lo_q         <= cfg_wdata[POS_W-1:0];
				REG_ROW_HI:         row_hi_q         <= cfg_wdata;
				REG_LINE_THRESHOLD: line_threshold_q <= cfg_wdata;
				REG_MIN_LINE_GAP:   min_line_gap_q   <= cfg_wdata[POS_W-1:0];
				REG_MIN_PEAK_SEP:   min_peak_sep_q   <= cfg_wdata[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rpld_result_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push_data0 (push_data0),
		.push_data1 (sum_res),
		.has_room   (has_room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

endmodule
`default_nettype wire

FILE: rtl/rpld_checker.sv
`default_nettype none
module rpld_checker import rpld_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input result_t result
);

	// A summary always closes the results of its pixel
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result.kind == KIND_SUMMARY)) |-> result.last)
		else $error("summary result without last");

	// Line events carry no second peak
	a_line_no_second: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result.kind == KIND_LINE))
		|-> ((result.second_row_pos == '0) && (result.second_count == '0)))
		else $error("line event with second peak fields set");

	// Second peak never outranks the best one
	a_peak_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result.kind == KIND_SUMMARY)) |-> (result.second_count <= result.count))
		else $error("second peak count above best count");

	// Counts saturate at the image dimension
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result.count <= CNT_MAX) && (result.line_total <= CNT_MAX)))
		else $error("count beyond saturation limit");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result)))
		else $error("stalled result changed");

endmodule

bind row_projection_line_detector rpld_checker u_rpld_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.result    (result)
);
`default_nettype wire

FILE: test/row_projection_line_detector_tb.sv
module row_projection_line_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpld_pkg::*;

	// Slack after the last expected result: a pixel that makes no result may still sit
	// in the input register when the result queue runs dry.
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_LIMIT   = 5000;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_PIXELS  = 62;

	// Index 7 decodes to no register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_INDEX = 3'd7;

	// Tracks the detector's row counts, top-two peaks and line events, and holds the
	// results still owed by the block in arrival order.
	class projection_scoreboard;
		logic [POS_W-1:0] col_lo_r, row_lo_r, line_gap_r, peak_sep_r;
		logic [CNT_W-1:0] col_hi_r, row_hi_r, threshold_r;
		logic [CNT_W-1:0] run_count, best_count, second_count, line_count;
		logic [POS_W-1:0] best_row, second_row, last_line_row;
		result_t          pending_events[$];
		int unsigned      mismatches;

		function new();
			col_lo_r    = 290;
			col_hi_r    = 870;
			row_lo_r    = 30;
			row_hi_r    = 787;
			threshold_r = 450;
			line_gap_r  = 8;
			peak_sep_r  = 5;
			mismatches  = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			run_count     = '0;
			best_count    = '0;
			best_row      = '0;
			second_count  = '0;
			second_row    = '0;
			last_line_row = '0;
			line_count    = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
			case (idx)
				REG_COL_LO:         col_lo_r    = val[POS_W-1:0];
				REG_COL_HI:         col_hi_r    = val;
				REG_ROW_LO:         row_lo_r    = val[POS_W-1:0];
				REG_ROW_HI:         row_hi_r    = val;
				REG_LINE_THRESHOLD: threshold_r = val;
				REG_MIN_LINE_GAP:   line_gap_r  = val[POS_W-1:0];
				REG_MIN_PEAK_SEP:   peak_sep_r  = val[POS_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(pixel_t px);
			result_t          ev;
			logic [CNT_W-1:0] closed;
			logic [CNT_W-1:0] swap_count;
			logic [POS_W-1:0] swap_row;
			int               peak_dist, line_dist;
			if (px.pixel_black && px.col >= col_lo_r && px.col < col_hi_r
					&& run_count < CNT_MAX)
				run_count++;
			if (px.row_end || px.frame_end) begin
				closed    = run_count;
				run_count = '0;
				if (px.row >= row_lo_r && px.row < row_hi_r) begin
					peak_dist = int'(px.row) - int'(best_row);
					line_dist = int'(px.row) - int'(last_line_row);
					if (second_count < closed && peak_dist > int'(peak_sep_r)) begin
						second_count = closed;
						second_row   = px.row;
						if (best_count < second_count) begin
							swap_count   = best_count;
							best_count   = second_count;
							second_count = swap_count;
							swap_row     = best_row;
							best_row     = second_row;
							second_row   = swap_row;
						end
					end
					if (closed > threshold_r && line_dist >= int'(line_gap_r)) begin
						last_line_row = px.row;
						if (line_count < CNT_MAX)
							line_count++;
						ev            = '0;
						ev.kind       = KIND_LINE;
						ev.row_pos    = px.row;
						ev.count      = closed;
						ev.line_total = line_count;
						ev.last       = !px.frame_end;
						pending_events.push_back(ev);
					end
				end
			end
			if (px.frame_end) begin
				ev.kind           = KIND_SUMMARY;
				ev.row_pos        = best_row;
				ev.count          = best_count;
				ev.second_row_pos = second_row;
				ev.second_count   = second_count;
				ev.line_total     = line_count;
				ev.last           = 1'b1;
				pending_events.push_back(ev);
				clear_frame();
			end
		endfunction

		function void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_events.size() == 0) begin
				$error("result with nothing expected: %p", got);
				mismatches++;
				return;
			end
			want = pending_events.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("row_pos", want.row_pos, got.row_pos);
			check_field("count", want.count, got.count);
			check_field("second_row_pos", want.second_row_pos, got.second_row_pos);
			check_field("second_count", want.second_count, got.second_count);
			check_field("line_total", want.line_total, got.line_total);
			check_field("last", want.last, got.last);
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	pixel_t               pixel     = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	result_t              result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_wdata = '0;

	projection_scoreboard sb = new();

	// Idle odds in percent per cycle, changed between phases.
	int unsigned send_gap_pct    = 0;
	int unsigned ready_stall_pct = 0;
	int unsigned cycle_count     = 0;

	row_projection_line_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Guard against a hung handshake: end the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL row_projection_line_detector");
			$finish;
		end
	end

	// Receiver: drop ready at random, sampled at the next rising edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= ready_stall_pct);
	end

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(result);
	end

	// Present one pixel and hold it until the transfer; gaps come before valid rises,
	// so valid never drops between back-to-back pixels.
	task automatic send_pixel(input logic blk, input logic [POS_W-1:0] col,
			input logic [POS_W-1:0] row, input logic rend, input logic fend);
		pixel_t px;
		px.pixel_black = blk;
		px.col         = col;
		px.row         = row;
		px.row_end     = rend;
		px.frame_end   = fend;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_pixel(px);
	endtask

	// Drop valid and wait until every owed result has arrived, then let the pipeline settle.
	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves the write enable high so that consecutive writes need no second assignment
	// in one step; apply_setting drops it afterward.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_setting(input logic [CNT_W-1:0] col_lo, input logic [CNT_W-1:0] col_hi,
			input logic [CNT_W-1:0] row_lo, input logic [CNT_W-1:0] row_hi,
			input logic [CNT_W-1:0] threshold, input logic [CNT_W-1:0] line_gap,
			input logic [CNT_W-1:0] peak_sep);
		write_reg(REG_COL_LO, col_lo);
		write_reg(REG_COL_HI, col_hi);
		write_reg(REG_ROW_LO, row_lo);
		write_reg(REG_ROW_HI, row_hi);
		write_reg(REG_LINE_THRESHOLD, threshold);
		write_reg(REG_MIN_LINE_GAP, line_gap);
		write_reg(REG_MIN_PEAK_SEP, peak_sep);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly small well-formed frames placed near the configured windows, with some
	// truncated frames, merged rows, row jumps and stray pixels mixed in.
	task automatic stream_frames(input int unsigned budget, input logic [POS_W-1:0] row_base,
			input logic [POS_W-1:0] col_base, input bit pause_midway);
		int unsigned      sent, width, area, cut, black_pct, idx;
		logic [POS_W-1:0] cur_row;
		logic             at_row_end;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) begin
				send_pixel(1'($urandom), POS_W'($urandom), POS_W'($urandom),
					$urandom_range(2) == 0, $urandom_range(4) == 0);
				sent++;
			end else begin
				width     = $urandom_range(9, 2);
				area      = width * $urandom_range(10, 2);
				cut       = ($urandom_range(7) == 0) ? $urandom_range(area - 1) : area - 1;
				black_pct = $urandom_range(100);
				cur_row   = row_base + POS_W'($urandom_range(3));
				for (idx = 0; idx <= cut; idx++) begin
					// advance to the next row, or now and then jump back or ahead in the area
					if (idx != 0 && idx % width == 0)
						cur_row = ($urandom_range(5) == 0) ?
							row_base + POS_W'($urandom_range(15)) : cur_row + 1'b1;
					at_row_end = (idx % width == width - 1) && ($urandom_range(19) != 0);
					send_pixel($urandom_range(99) < black_pct, col_base + POS_W'(idx % width),
						cur_row, at_row_end, idx == cut);
					sent++;
					// hold off the sender once until the result queue has emptied
					if (pause_midway && sent == budget / 2)
						wait_drained();
				end
			end
		end
	endtask

	initial begin
		int unsigned      phase;
		logic [POS_W-1:0] row_base, col_base;
		logic [CNT_W-1:0] lo_c, hi_c, lo_r, hi_r;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: pixels on both sides of each window edge, a row outside the
		// band on each side, and a frame closing on an out-of-band row.
		send_pixel(1'b1, 289, 29, 1'b0, 1'b0);
		send_pixel(1'b1, 290, 29, 1'b0, 1'b0);
		send_pixel(1'b1, 869, 29, 1'b0, 1'b0);
		send_pixel(1'b1, 870, 29, 1'b1, 1'b0);
		send_pixel(1'b1, 290, 30, 1'b0, 1'b0);
		send_pixel(1'b1, 869, 30, 1'b1, 1'b0);
		send_pixel(1'b1, 500, 786, 1'b1, 1'b0);
		send_pixel(1'b1, 500, 787, 1'b1, 1'b0);
		send_pixel(1'b0, 2047, 2047, 1'b1, 1'b1);
		wait_drained();

		// Widest windows, zero threshold, gap and separation: field extremes, a row
		// before the last line row, frame end without row end, then with it.
		apply_setting(0, CNT_MAX, 0, CNT_MAX, 0, 0, 0);
		send_pixel(1'b1, 0, 0, 1'b0, 1'b0);
		send_pixel(1'b1, 2047, 0, 1'b1, 1'b0);
		send_pixel(1'b1, 5, 2047, 1'b1, 1'b0);
		send_pixel(1'b0, 100, 10, 1'b1, 1'b0);
		send_pixel(1'b1, 1, 3, 1'b0, 1'b1);
		send_pixel(1'b1, 0, 0, 1'b1, 1'b1);
		wait_drained();

		// Inverted windows and largest limits; an out-of-range index and an oversized
		// value that the 11-bit register truncates.
		write_reg(REG_UNUSED_INDEX, 12'd1);
		apply_setting(12'hFFF, 0, 2047, 0, CNT_MAX, 2047, 2047);
		send_pixel(1'b1, 2047, 2047, 1'b1, 1'b0);
		send_pixel(1'b1, 0, 0, 1'b0, 1'b1);
		wait_drained();

		// Random phases: each moves the windows to a fresh spot and picks an idle pattern.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
				1: begin send_gap_pct = 77; ready_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  ready_stall_pct = 77; end
				default: begin send_gap_pct = 21; ready_stall_pct = 21; end
			endcase
			row_base = POS_W'($urandom);
			col_base = POS_W'($urandom);
			lo_c = {1'b0, POS_W'(col_base + POS_W'($urandom_range(2)))};
			hi_c = lo_c + CNT_W'($urandom_range(9));
			if (hi_c > CNT_MAX)
				hi_c = CNT_MAX;
			lo_r = {1'b0, POS_W'(row_base + POS_W'($urandom_range(3)))};
			hi_r = lo_r + CNT_W'($urandom_range(12, 1));
			if (hi_r > CNT_MAX)
				hi_r = CNT_MAX;
			apply_setting(lo_c, hi_c, lo_r, hi_r, CNT_W'($urandom_range(5)),
				CNT_W'($urandom_range(4)), CNT_W'($urandom_range(4)));
			stream_frames(PHASE_PIXELS, row_base, col_base, phase == 2);
			wait_drained();
		end

		if (sb.pending_events.size() != 0) begin
			$error("%0d expected results never arrived", sb.pending_events.size());
			sb.mismatches++;
		end
		if (sb.mismatches == 0) begin
			$display("PASS row_projection_line_detector");
		end else begin
			$display("FAIL row_projection_line_detector");
		end
		$finish;
	end

endmodule
